// ----- design/signature_length_deframer_defines.svh -----
// Assertion macros of the signature length deframer checker.
`ifndef SIGNATURE_LENGTH_DEFRAMER_DEFINES_SVH
`define SIGNATURE_LENGTH_DEFRAMER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sld_pkg.sv -----
// Types and constants of the signature length deframer.
package sld_pkg;

  // Header signature as it sits in the window for each byte order
  localparam logic [31:0] Signature        = 32'hDEADBEEF;
  localparam logic [31:0] SignatureSwapped = 32'hEFBEADDE;

  // Reset value of the largest accepted payload length
  localparam logic [30:0] DefaultMaxPacket = 31'd16376;

  // Byte count value of the last byte of a header word
  localparam logic [1:0] LastWordByte = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgMaxPacket = 2'd0;
  localparam logic [1:0] CfgByteOrder = 2'd1;

  // Parser phase; the unused codes act as expecting signature
  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HUNT = 3'd1,
    PH_LEN  = 3'd2,
    PH_BODY = 3'd3
  } phase_e;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2,
    KIND_MISMATCH = 2'd3
  } kind_e;

endpackage

// ----- design/signature_length_deframer.sv -----
// Top level of the signature length deframer.
// The deframer takes one received byte per cycle and splits the stream into packets with an
// 8-byte header: the signature 0xDEADBEEF and a 32-bit payload length, both in the byte order
// set by register 1 (0 big-endian, 1 little-endian). Payload bytes come out as kind 0 with
// packet_last on the final byte; an empty packet gives one kind 1 marker with packet_last set;
// a length above register 0 (max_packet_size) gives one kind 2 result and its payload is
// discarded; a bad signature gives one kind 3 result and the parser then slides byte by byte
// until it finds a signature. Header and dropped bytes give no result. The block sustains one
// byte per cycle: each byte passes through an input register, one compare-and-count step and
// a result register; its result is loaded into the result register as the held byte advances.
// The input stalls only while the input register holds a byte and the result register is held
// by a stalled receiver. The configuration port is always ready.
module signature_length_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_result_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_packet_last_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  import sld_pkg::*;

  // configuration registers
  logic [30:0] max_q;
  logic        order_q;

  // input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [31:0] window_q, window_d;
  logic [1:0]  count_q, count_d;
  logic [31:0] remain_q, remain_d;
  logic        drop_q, drop_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // per-byte work
  logic        proc_go;
  logic [31:0] win_shift;
  logic [31:0] sig_want;
  logic [31:0] len_word;
  logic        sig_match;
  logic        len_zero;
  logic        len_over;
  logic        emit;
  kind_e       kind;
  logic [7:0]  res_byte;
  logic        res_last;

  assign cfg_ready_o = 1'b1;

  // take configuration writes; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= DefaultMaxPacket;
      order_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMaxPacket: max_q   <= cfg_data_i;
        CfgByteOrder: order_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // advance the held byte when the result register can take a result
  assign proc_go    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc_go;

  // hold the accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // shift the byte into the header window and decode the header word
  assign win_shift = {window_q[23:0], in_byte_q};
  assign sig_want  = order_q ? SignatureSwapped : Signature;
  assign sig_match = (win_shift == sig_want);
  assign len_word  = order_q ? {win_shift[7:0], win_shift[15:8], win_shift[23:16],
                                win_shift[31:24]}
                             : win_shift;
  assign len_zero  = (len_word == 32'd0);
  assign len_over  = (len_word > {1'b0, max_q});

  // next parser state
  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    count_d  = count_q;
    remain_d = remain_q;
    drop_d   = drop_q;
    if (proc_go) begin
      unique case (phase_q)
        PH_HUNT: begin
          window_d = win_shift;
          if (sig_match) begin
            phase_d  = PH_LEN;
            count_d  = 2'd0;
            window_d = 32'd0;
          end
        end
        PH_LEN: begin
          window_d = win_shift;
          if (count_q != LastWordByte) begin
            count_d = count_q + 2'd1;
          end else begin
            count_d  = 2'd0;
            window_d = 32'd0;
            if (len_zero) begin
              phase_d  = PH_SIG;
              remain_d = 32'd0;
              drop_d   = 1'b0;
            end else begin
              phase_d  = PH_BODY;
              remain_d = len_word;
              drop_d   = len_over;
            end
          end
        end
        PH_BODY: begin
          if (remain_q == 32'd0) begin
            // resync on this byte as the first signature byte
            phase_d  = PH_SIG;
            window_d = {24'd0, in_byte_q};
            count_d  = 2'd1;
            remain_d = 32'd0;
            drop_d   = 1'b0;
          end else if (remain_q == 32'd1) begin
            phase_d  = PH_SIG;
            window_d = 32'd0;
            count_d  = 2'd0;
            remain_d = 32'd0;
            drop_d   = 1'b0;
          end else begin
            remain_d = remain_q - 32'd1;
          end
        end
        default: begin
          phase_d  = PH_SIG;
          window_d = win_shift;
          if (count_q != LastWordByte) begin
            count_d = count_q + 2'd1;
          end else begin
            count_d = 2'd0;
            if (sig_match) begin
              phase_d  = PH_LEN;
              window_d = 32'd0;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        end
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    emit     = 1'b0;
    kind     = KIND_PAYLOAD;
    res_byte = 8'd0;
    res_last = 1'b0;
    unique case (phase_q)
      PH_HUNT: ;
      PH_LEN: begin
        if (count_q == LastWordByte) begin
          if (len_zero) begin
            emit     = 1'b1;
            kind     = KIND_EMPTY;
            res_last = 1'b1;
          end else if (len_over) begin
            emit = 1'b1;
            kind = KIND_OVERSIZE;
          end
        end
      end
      PH_BODY: begin
        if (remain_q != 32'd0 && !drop_q) begin
          emit     = 1'b1;
          kind     = KIND_PAYLOAD;
          res_byte = in_byte_q;
          res_last = (remain_q == 32'd1);
        end
      end
      default: begin
        if (count_q == LastWordByte && !sig_match) begin
          emit = 1'b1;
          kind = KIND_MISMATCH;
        end
      end
    endcase
  end

  // update parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      window_q <= 32'd0;
      count_q  <= 2'd0;
      remain_q <= 32'd0;
      drop_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      drop_q   <= drop_d;
    end
  end

  // load a new result, or drop the one just taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (proc_go) begin
      out_vld_d = emit;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && emit) begin
      kind_q <= kind;
      byte_q <= res_byte;
      last_q <= res_last;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_result_kind_o = kind_q;
  assign out_byte_o        = byte_q;
  assign out_packet_last_o = last_q;

endmodule

// ----- design/sld_checker.sv -----
// Port checker of the signature length deframer and its bind.
`include "signature_length_deframer_defines.svh"

module sld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_result_kind_o,
  input logic [7:0] out_byte_o,
  input logic       out_packet_last_o
);
  import sld_pkg::*;

  logic        out_held;
  logic [10:0] out_item;
  logic        marker_item;
  logic        error_item;

  // classify what the output shows this cycle
  assign out_held    = out_valid_o && out_stall_i;
  assign out_item    = {out_result_kind_o, out_byte_o, out_packet_last_o};
  assign marker_item = out_valid_o && (out_result_kind_o != KIND_PAYLOAD);
  assign error_item  = out_valid_o && (out_result_kind_o == KIND_OVERSIZE ||
                                       out_result_kind_o == KIND_MISMATCH);

  // a stalled item stays offered
  `SLD_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "stalled item withdrawn")

  // a stalled item keeps its payload
  `SLD_ASSERT_NEXT(a_out_stable, out_held, $stable(out_item), "stalled item changed")

  // only payload items carry a byte
  `SLD_ASSERT_SAME(a_byte_zero, marker_item, out_byte_o == 8'd0, "byte set on a marker item")

  // only payload and empty-packet items close a packet
  `SLD_ASSERT_SAME(a_last_kind, error_item, !out_packet_last_o, "last set on an error item")

endmodule

bind signature_length_deframer sld_checker u_sld_checker (.*);

// ----- tb/sv/signature_length_deframer_tb.sv -----
// Self-checking testbench of the signature length deframer.
`timescale 1ns / 100ps

module signature_length_deframer_tb;
  import sld_pkg::*;

  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseBytes   = 75;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } deframe_result_t;

  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgMaxPacket;
  logic [30:0] cfg_data  = '0;

  // Predicted parser state and register copies
  logic [31:0] hdr_window;
  phase_e      parse_phase;
  logic [1:0]  hdr_count;
  logic [31:0] left_bytes;
  logic        drop_payload;
  logic [30:0] max_len;
  logic        little_endian;

  logic [7:0]      stream_bytes[$];
  deframe_result_t predicted_results[$];

  // Run control shared by the stimulus and the two channel processes
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;
  int unsigned hold_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors     = 0;
  logic            drv_hit;
  deframe_result_t drv_res;
  deframe_result_t mon_exp;

  signature_length_deframer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_byte_i        (in_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_result_kind_o(out_kind),
    .out_byte_o       (out_byte),
    .out_packet_last_o(out_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Pick an idle gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit enable);
    int unsigned r;
    r = $urandom_range(99);
    if (!enable || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Return the parser to the start of a header
  task automatic restart_header();
    parse_phase  = PH_SIG;
    hdr_count    = '0;
    hdr_window   = '0;
    left_bytes   = '0;
    drop_payload = 1'b0;
  endtask

  // Advance the predicted parser by one byte and give the result it causes
  task automatic deframe_byte(input logic [7:0] b, output logic hit,
                              output deframe_result_t res);
    logic [31:0] want;
    logic [31:0] len;
    logic        drop;
    hit  = 1'b0;
    res  = '{KIND_PAYLOAD, 8'h00, 1'b0};
    want = little_endian ? SignatureSwapped : Signature;
    case (parse_phase)
      PH_HUNT: begin
        hdr_window = {hdr_window[23:0], b};
        if (hdr_window == want) begin
          parse_phase = PH_LEN;
          hdr_count   = '0;
          hdr_window  = '0;
        end
      end
      PH_LEN: begin
        hdr_window = {hdr_window[23:0], b};
        if (hdr_count != LastWordByte) begin
          hdr_count = hdr_count + 2'd1;
        end else begin
          len = little_endian ? {hdr_window[7:0], hdr_window[15:8], hdr_window[23:16],
                                 hdr_window[31:24]} : hdr_window;
          hdr_count  = '0;
          hdr_window = '0;
          if (len == 32'd0) begin
            restart_header();
            hit = 1'b1;
            res = '{KIND_EMPTY, 8'h00, 1'b1};
          end else begin
            parse_phase = PH_BODY;
            left_bytes  = len;
            if (len > {1'b0, max_len}) begin
              drop_payload = 1'b1;
              hit = 1'b1;
              res = '{KIND_OVERSIZE, 8'h00, 1'b0};
            end else begin
              drop_payload = 1'b0;
            end
          end
        end
      end
      PH_BODY: begin
        drop = drop_payload;
        if (left_bytes == 32'd0) begin
          // resync on this byte
          restart_header();
          hdr_window = {24'd0, b};
          hdr_count  = 2'd1;
        end else begin
          left_bytes = left_bytes - 32'd1;
          if (left_bytes == 32'd0) restart_header();
          if (!drop) begin
            hit = 1'b1;
            res = '{KIND_PAYLOAD, b, left_bytes == 32'd0};
          end
        end
      end
      default: begin
        parse_phase = PH_SIG;
        hdr_window  = {hdr_window[23:0], b};
        if (hdr_count != LastWordByte) begin
          hdr_count = hdr_count + 2'd1;
        end else begin
          hdr_count = '0;
          if (hdr_window == want) begin
            parse_phase = PH_LEN;
            hdr_window  = '0;
          end else begin
            parse_phase = PH_HUNT;
            hit = 1'b1;
            res = '{KIND_MISMATCH, 8'h00, 1'b0};
          end
        end
      end
    endcase
  endtask

  // Queue one header word in the current byte order
  task automatic push_word(input logic [31:0] w);
    if (little_endian) begin
      stream_bytes.push_back(w[7:0]);
      stream_bytes.push_back(w[15:8]);
      stream_bytes.push_back(w[23:16]);
      stream_bytes.push_back(w[31:24]);
    end else begin
      stream_bytes.push_back(w[31:24]);
      stream_bytes.push_back(w[23:16]);
      stream_bytes.push_back(w[15:8]);
      stream_bytes.push_back(w[7:0]);
    end
  endtask

  // Queue a well-formed packet with random payload
  task automatic push_packet(input logic [31:0] len);
    push_word(Signature);
    push_word(len);
    repeat (len) stream_bytes.push_back(8'($urandom));
  endtask

  // Queue a byte that can never complete a signature in either order
  task automatic push_junk_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == Signature[31:24] || b == Signature[7:0]);
    stream_bytes.push_back(b);
  endtask

  // Queue a signature with its last byte broken
  task automatic push_broken_signature();
    logic [31:0] w;
    w = little_endian ? SignatureSwapped : Signature;
    stream_bytes.push_back(w[31:24]);
    stream_bytes.push_back(w[23:16]);
    stream_bytes.push_back(w[15:8]);
    push_junk_byte();
  endtask

  // Wait until the sender is drained, every result is in and the pipeline is empty
  task automatic wait_idle();
    while (stream_bytes.size() != 0 || in_valid) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register and update the predictor copy
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgMaxPacket) max_len = val;
    else if (idx == CfgByteOrder) little_endian = val[0];
    @(posedge clk_i);
  endtask

  // Drive bytes from the queue, predict on each accepted item
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, drv_hit, drv_res);
        if (drv_hit) predicted_results.push_back(drv_res);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (stream_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= stream_bytes.pop_front();
          tx_gap   <= pick_gap(tx_idle_en);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check accepted results and drive the receiver stall
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h last %b",
                   $time, out_kind, out_byte, out_last);
          errors++;
        end else begin
          mon_exp = predicted_results.pop_front();
          if (out_kind !== mon_exp.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, mon_exp.kind, out_kind);
            errors++;
          end
          if (out_byte !== mon_exp.data) begin
            $display("%0t: byte expected %h actual %h", $time, mon_exp.data, out_byte);
            errors++;
          end
          if (out_last !== mon_exp.last) begin
            $display("%0t: last expected %b actual %b", $time, mon_exp.last, out_last);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap    <= rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap    <= pick_gap(rx_idle_en);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    max_len       = DefaultMaxPacket;
    little_endian = 1'b0;
    restart_header();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Empty packet, short packet, bad signature then hunt into an empty packet
    push_packet(32'd0);
    push_word(Signature);
    push_word(32'd2);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    push_word(32'hDEADBEEE);
    stream_bytes.push_back(8'hAD);
    push_packet(32'd0);
    wait_idle();

    // Length equal to and above a small maximum
    write_reg(CfgMaxPacket, 31'd2);
    push_packet(32'd3);
    push_packet(32'd2);
    wait_idle();

    // Zero maximum: empty still reported, anything else dropped
    write_reg(CfgMaxPacket, 31'd0);
    push_packet(32'd0);
    push_packet(32'd1);
    wait_idle();

    // Little-endian packet, ignored indexes, byte order switched inside a length word
    write_reg(CfgMaxPacket, 31'h7FFF_FFFF);
    write_reg(CfgByteOrder, 31'h7FFF_FFFF);
    write_reg(2'd2, 31'd0);
    write_reg(2'd3, 31'h7FFF_FFFE);
    push_packet(32'd1);
    push_word(Signature);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    wait_idle();
    write_reg(CfgByteOrder, 31'h7FFF_FFFE);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h02);
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'h7F);
    wait_idle();

    // Random phases, each with its own settings and idle pattern
    for (int p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(5))
        0: write_reg(CfgMaxPacket, 31'd0);
        1: write_reg(CfgMaxPacket, 31'd1);
        2: write_reg(CfgMaxPacket, 31'($urandom_range(16, 2)));
        3: write_reg(CfgMaxPacket, DefaultMaxPacket);
        4: write_reg(CfgMaxPacket, 31'h7FFF_FFFF);
        default: write_reg(CfgMaxPacket, 31'($urandom_range(30, 4)));
      endcase
      write_reg(CfgByteOrder, 31'($urandom));
      if ($urandom_range(3) == 0) write_reg(2'($urandom_range(3, 2)), 31'($urandom));
      if (p == 2) begin
        // Fill the block against a long receiver hold-off
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
      end else begin
        tx_idle_en = ($urandom_range(3) != 0);
        rx_idle_en = ($urandom_range(3) != 0);
      end
      while (stream_bytes.size() < PhaseBytes) begin
        r = $urandom_range(9);
        if (r == 0) begin
          repeat ($urandom_range(12, 4)) push_junk_byte();
        end else if (r == 1) begin
          push_broken_signature();
        end else if ($urandom_range(7) != 0) begin
          push_packet($urandom_range(12, 0));
        end else begin
          push_packet($urandom_range(40, 13));
        end
      end
      wait_idle();
    end

    // A length-3 packet, then an oversize length with the top bit set, its payload dropped
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    push_packet(32'd3);
    push_word(Signature);
    push_word({1'b1, 31'($urandom)});
    repeat (10) stream_bytes.push_back(8'($urandom));
    wait_idle();

    errors += predicted_results.size();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
